// ----- src/assert_macros.svh -----
// assertion macros shared by the coefficient packer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CCP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ccp assertion failed");

// consequent must hold in the cycle after the antecedent
`define CCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccp assertion failed");

`endif

// ----- src/ccp_pkg.sv -----
// package with constants, types and the divide-by-q helper of the coefficient packer
`timescale 1ns / 1ps

package ccp_pkg;

    localparam int POLY_COEFFS = 256;
    localparam int CNT_W       = $clog2(POLY_COEFFS);

    localparam logic [11:0] MODULUS_Q = 12'd3329;
    localparam logic [10:0] HALF_Q    = 11'd1664;
    // ten times q, keeps the shifted coefficient positive
    localparam logic [16:0] Q_OFFSET  = 17'd33290;

    // ceil(2^34 / q), exact for dividends below 2^22
    localparam int          RECIP_SHIFT = 34;
    localparam logic [22:0] RECIP_Q     = 23'd5160670;

    localparam logic [1:0] MODE_D1  = 2'd0;
    localparam logic [1:0] MODE_D4  = 2'd1;
    localparam logic [1:0] MODE_D10 = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       poly_last;
    } ccp_result_t;

    typedef struct packed {
        logic [1:0]  count;
        ccp_result_t first;
        ccp_result_t second;
    } ccp_push_t;

    function automatic logic [10:0] div_q(input logic [21:0] value);
        logic [44:0] prod;
        prod = {23'd0, value} * {22'd0, RECIP_Q};
        return prod[RECIP_SHIFT +: 11];
    endfunction

endpackage

// ----- src/ccp_out_buf.sv -----
// two-entry result queue between the packing stage and the byte output
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccp_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  ccp_pkg::ccp_push_t  push,
    output logic [1:0]          free,
    output logic                out_valid,
    input  logic                out_ready,
    output ccp_pkg::ccp_result_t head
);
    import ccp_pkg::*;

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    ccp_result_t slot0_reg;
    ccp_result_t slot0_next;
    ccp_result_t slot1_reg;
    ccp_result_t slot1_next;
    logic        pop;
    logic [1:0]  cnt_left;
    ccp_result_t base0;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && out_ready;
    assign cnt_left  = cnt_reg - {1'b0, pop};
    assign free      = 2'd2 - cnt_left;
    assign base0     = pop ? slot1_reg : slot0_reg;

    always_comb
    begin
        cnt_next = cnt_left + push.count;
        if (cnt_left == 2'd0)
        begin
            slot0_next = push.first;
            slot1_next = push.second;
        end
        else if (cnt_left == 2'd1)
        begin
            slot0_next = base0;
            slot1_next = push.first;
        end
        else
        begin
            slot0_next = slot0_reg;
            slot1_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `CCP_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg != 2'd3)
    `CCP_ASSERT_ALWAYS(a_push_fits, clk, rst_n, push.count <= free)

endmodule

// ----- src/coeff_compress_and_pack_top.sv -----
// coefficient reduce, compress and byte pack pipeline, top level
// path: coeff_reg, then u_reg and quot_reg, then x_reg, then the result queue that offers the bytes
// throughput: one item per cycle, bounded by the one-byte output channel
// (1 byte per 8 coefficients, 1 per 2, or 1.25 bytes per coefficient by mode)
// reset: pipeline and result queue empty, accumulator and count zero, ten-bit mode
`timescale 1ns / 1ps
`include "assert_macros.svh"

module coeff_compress_and_pack_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] coefficient,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  packed_byte,
    output logic        run_last,
    output logic        poly_last
);
    import ccp_pkg::*;

    logic [1:0]       mode_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic [15:0]      coeff_reg;
    logic [16:0]      u_reg;
    logic [4:0]       quot_reg;
    logic [11:0]      x_reg;
    logic [7:0]       acc_reg;
    logic [7:0]       acc_next;
    logic [2:0]       held_reg;
    logic [2:0]       held_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             take1;
    logic             take2;
    logic             take3;
    logic             fire3;
    logic [16:0]      u_calc;
    logic [10:0]      quot_u;
    logic [16:0]      qq_prod;
    logic [16:0]      x_calc;
    logic [3:0]       d;
    logic [9:0]       d_mask;
    logic [21:0]      t_val;
    logic [10:0]      quot_t;
    logic [9:0]       comp;
    logic [17:0]      acc_wide;
    logic [4:0]       held_sum;
    logic             final_coeff;
    logic             poly_cleared;
    ccp_push_t        push_req;
    ccp_push_t        push;
    logic [1:0]       free;
    ccp_result_t      head;

    // pipeline advance
    assign fire3    = v3_reg && (push_req.count <= free);
    assign take3    = v2_reg && (!v3_reg || fire3);
    assign take2    = v1_reg && (!v2_reg || take3);
    assign in_ready = !v1_reg || take2;
    assign take1    = in_valid && in_ready;

    // stage 1: quotient of the offset coefficient by q
    assign u_calc = {coeff_reg[15], coeff_reg} + Q_OFFSET;
    assign quot_u = div_q({5'd0, u_calc});

    // stage 2: remainder mod q
    assign qq_prod = {12'd0, quot_reg} * {5'd0, MODULUS_Q};
    assign x_calc  = u_reg - qq_prod;

    // stage 3: compress and pack
    always_comb
    begin
        unique case (mode_reg)
            MODE_D1:
            begin
                d      = 4'd1;
                d_mask = 10'h001;
            end
            MODE_D4:
            begin
                d      = 4'd4;
                d_mask = 10'h00F;
            end
            default:
            begin
                d      = 4'd10;
                d_mask = 10'h3FF;
            end
        endcase
    end

    assign t_val       = ({10'd0, x_reg} << d) + {11'd0, HALF_Q};
    assign quot_t      = div_q(t_val);
    assign comp        = quot_t[9:0] & d_mask;
    assign acc_wide    = {10'd0, acc_reg} | ({8'd0, comp} << held_reg);
    assign held_sum    = {2'd0, held_reg} + {1'b0, d};
    assign final_coeff = (count_reg == CNT_W'(POLY_COEFFS - 1));

    always_comb
    begin
        push_req.second.data      = acc_wide[15:8];
        push_req.second.run_last  = 1'b1;
        push_req.second.poly_last = final_coeff;
        push_req.first.data       = acc_wide[7:0];
        if (held_sum >= 5'd16)
        begin
            push_req.count           = 2'd2;
            push_req.first.run_last  = 1'b0;
            push_req.first.poly_last = 1'b0;
            acc_next                 = {6'd0, acc_wide[17:16]};
        end
        else if (held_sum >= 5'd8)
        begin
            push_req.count           = 2'd1;
            push_req.first.run_last  = 1'b1;
            push_req.first.poly_last = final_coeff;
            acc_next                 = acc_wide[15:8];
        end
        else
        begin
            push_req.count           = 2'd0;
            push_req.first.run_last  = 1'b1;
            push_req.first.poly_last = final_coeff;
            acc_next                 = acc_wide[7:0];
        end
        held_next  = held_sum[2:0];
        count_next = count_reg + CNT_W'(1);
        if (final_coeff)
        begin
            acc_next   = 8'd0;
            held_next  = 3'd0;
            count_next = '0;
        end
    end

    always_comb
    begin
        push       = push_req;
        push.count = fire3 ? push_req.count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_D10;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            acc_reg   <= 8'd0;
            held_reg  <= 3'd0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (take1)
            begin
                v1_reg <= 1'b1;
            end
            else if (take2)
            begin
                v1_reg <= 1'b0;
            end
            if (take2)
            begin
                v2_reg <= 1'b1;
            end
            else if (take3)
            begin
                v2_reg <= 1'b0;
            end
            if (take3)
            begin
                v3_reg <= 1'b1;
            end
            else if (fire3)
            begin
                v3_reg <= 1'b0;
            end
            if (fire3)
            begin
                acc_reg   <= acc_next;
                held_reg  <= held_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            coeff_reg <= coefficient;
        end
        if (take2)
        begin
            u_reg    <= u_calc;
            quot_reg <= quot_u[4:0];
        end
        if (take3)
        begin
            x_reg <= x_calc[11:0];
        end
    end

    ccp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign packed_byte = head.data;
    assign run_last    = head.run_last;
    assign poly_last   = head.poly_last;

    assign poly_cleared = (count_reg == '0) && (held_reg == 3'd0) && (acc_reg == 8'd0);

    `CCP_ASSERT_NEXT(a_poly_end_clears, clk, rst_n, fire3 && final_coeff, poly_cleared)
    `CCP_ASSERT_ALWAYS(a_stall_needs_queue, clk, rst_n, !(v3_reg && !fire3) || (free != 2'd2))
    `CCP_ASSERT_ALWAYS(a_remainder_range, clk, rst_n, !v3_reg || (x_reg < MODULUS_Q))

endmodule
